/* sv/rat_pkg.sv */
// Shared types and constants of the range address translation table.
// Used by rat_front, rat_engine and range_address_translation_table.
`timescale 1ns / 1ps

package rat_pkg;

    localparam int VA_W   = 64;
    localparam int LEN_W  = 48;
    localparam int PA_W   = 64;
    localparam int SLOT_W = 6;
    localparam int HIT_W  = 32;
    localparam int IN_W   = 176;
    localparam int OUT_W  = 104;

    localparam logic [HIT_W-1:0] HITS_MAX = {HIT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_BIND   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_TRANS  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_MISS    = 2'd2,
        STS_UNBOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_TRANS = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_READ,
        FS_EVAL,
        FS_PREAD,
        FS_PEVAL
    } t_fsm;

    typedef struct packed {
        t_req              req;
        logic [VA_W-1:0]   addr;
        logic [LEN_W-1:0]  len;
        logic [PA_W-1:0]   pbase;
    } t_cmd;

    typedef struct packed {
        t_mode             mode;
        logic [VA_W-1:0]   vbase;
        logic [LEN_W-1:0]  len;
        logic [PA_W-1:0]   pbase;
        logic [HIT_W-1:0]  hits;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [PA_W-1:0]   paddr;
        logic [SLOT_W-1:0] slot;
        logic [HIT_W-1:0]  hits;
    } t_result;

endpackage

/* sv/rat_front.sv */
// Front end: accepts request transactions, decodes them into commands
// and holds them in a two-entry queue. Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_front import rat_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_in_kind,
    input  logic [IN_W-1:0] i_in_data,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  logic            i_cmd_pop
);

    t_cmd       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    assign w_cmd.req   = t_req'(i_in_kind);
    assign w_cmd.addr  = i_in_data[63:0];
    assign w_cmd.len   = i_in_data[111:64];
    assign w_cmd.pbase = i_in_data[175:112];

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_buf[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* sv/rat_engine.sv */
// Back end: range table memory, slot scan, read-modify-write of one entry,
// fill mark pullback and result register. Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_engine import rat_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    t_entry        mem [ENTRIES];
    t_entry        r_rd;
    logic          we;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    t_fsm          r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_out_valid, n_out_valid;
    t_result       r_res, n_res;

    logic [VA_W-1:0]      diff;
    logic                 in_range;
    logic [FW-1:0]        idx_ext;
    logic [FW-1:0]        idx_inc;
    logic                 full;
    logic                 start;
    logic [IW+SLOT_W-1:0] idx_wide;
    logic [FW+SLOT_W-1:0] fill_wide;
    logic [SLOT_W-1:0]    idx_slot;
    logic [SLOT_W-1:0]    fill_slot;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[r_idx];
    end

    assign diff      = r_cmd.addr - r_rd.vbase;
    assign in_range  = (r_rd.mode != MODE_FREE) && (r_cmd.addr >= r_rd.vbase) &&
                       (diff < {{(VA_W-LEN_W){1'b0}}, r_rd.len});
    assign idx_ext   = FW'(r_idx);
    assign idx_inc   = idx_ext + 1'b1;
    assign full      = (r_fill == FW'(ENTRIES));
    assign start     = (r_state == FS_IDLE) && i_cmd_valid && !r_out_valid;
    assign idx_wide  = {{SLOT_W{1'b0}}, r_idx};
    assign fill_wide = {{SLOT_W{1'b0}}, r_fill};
    assign idx_slot  = idx_wide[SLOT_W-1:0];
    assign fill_slot = fill_wide[SLOT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (start && i_cmd.req != REQ_ALLOC && r_fill != '0) begin
                    n_state = FS_READ;
                end
            end
            FS_READ: begin
                n_state = FS_EVAL;
            end
            FS_EVAL: begin
                if (in_range) begin
                    if (r_cmd.req == REQ_REMOVE && idx_inc == r_fill && r_idx != '0) begin
                        n_state = FS_PREAD;
                    end else begin
                        n_state = FS_IDLE;
                    end
                end else if (idx_inc >= r_fill) begin
                    n_state = FS_IDLE;
                end else begin
                    n_state = FS_READ;
                end
            end
            FS_PREAD: begin
                n_state = FS_PEVAL;
            end
            FS_PEVAL: begin
                if (r_rd.mode == MODE_FREE && r_idx != '0) begin
                    n_state = FS_PREAD;
                end else begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rd;
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            FS_IDLE: begin
                if (start) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_res     = '0;
                    if (i_cmd.req == REQ_ALLOC) begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_res.status = STS_FULL;
                        end else begin
                            we            = 1'b1;
                            wr_addr       = IW'(r_fill);
                            wr_data.mode  = MODE_ALLOC;
                            wr_data.vbase = i_cmd.addr;
                            wr_data.len   = i_cmd.len;
                            wr_data.pbase = i_cmd.pbase;
                            wr_data.hits  = '0;
                            n_fill        = r_fill + 1'b1;
                            n_res.slot    = fill_slot;
                        end
                    end else if (r_fill == '0) begin
                        n_out_valid  = 1'b1;
                        n_res.status = STS_MISS;
                    end
                end
            end
            FS_EVAL: begin
                if (in_range) begin
                    n_out_valid = 1'b1;
                    n_res.slot  = idx_slot;
                    unique case (r_cmd.req)
                        REQ_BIND: begin
                            we            = 1'b1;
                            wr_data.mode  = MODE_TRANS;
                            wr_data.pbase = r_cmd.pbase;
                        end
                        REQ_REMOVE: begin
                            we         = 1'b1;
                            wr_data    = '0;
                            n_res.hits = r_rd.hits;
                            if (idx_inc == r_fill) begin
                                n_fill = idx_ext;
                                n_idx  = r_idx - 1'b1;
                            end
                        end
                        REQ_TRANS: begin
                            if (r_rd.mode == MODE_TRANS) begin
                                we           = 1'b1;
                                n_res.paddr  = r_rd.pbase + diff;
                                if (r_rd.hits != HITS_MAX) begin
                                    wr_data.hits = r_rd.hits + 1'b1;
                                end
                                n_res.hits   = wr_data.hits;
                            end else begin
                                n_res.status = STS_UNBOUND;
                            end
                        end
                        default: begin
                            n_res.status = STS_OK;
                        end
                    endcase
                end else if (idx_inc >= r_fill) begin
                    n_out_valid  = 1'b1;
                    n_res.status = STS_MISS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            FS_PEVAL: begin
                if (r_rd.mode == MODE_FREE) begin
                    n_fill = idx_ext;
                    n_idx  = r_idx - 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (!r_out_valid && r_state == FS_IDLE))
        else $error("command taken while result pending");

    a_scan_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_EVAL) |-> (idx_ext < r_fill))
        else $error("scan beyond fill mark");

    a_alloc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.req == REQ_ALLOC && !full) |=>
        (r_fill == $past(r_fill) + 1'b1))
        else $error("fill mark did not advance on allocate");

endmodule

/* sv/range_address_translation_table.sv */
// Allocate writes its entry and result straight from idle; bind, remove and translate
// scan slots in order up to the first covering slot, or up to the fill mark.
// A remove of the top slot then holds off the next request while the fill mark is pulled back over free slots.
// The table engine handles one request at a time; a two-entry queue buffers input.
// Reset clears the fill mark, queue and handshakes; table contents are not cleared.
// Top level; depends on rat_pkg, rat_front, rat_engine.
`timescale 1ns / 1ps

module range_address_translation_table import rat_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // virt_addr, range_length, phys_base
    input  logic [1:0]       s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // phys_addr, slot, hit_total, zero pad
    output logic [1:0]       m_axis_tuser    // status
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result res;

    rat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_kind   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    rat_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {2'b00, res.hits, res.slot, res.paddr};

endmodule
